[rtl/core/bmprle_pkg.sv]
// ----------------------------------------------------------------------------
// bmprle_pkg
// shared types and constants of the bmp rle8/rle4 run decoder
// ----------------------------------------------------------------------------
package bmprle_pkg;

	// default limit on the image side
	localparam int MAX_SIDE_DEF = 20000;

	// field widths
	localparam int DimW   = 15;
	localparam int CurW   = 16;
	localparam int ByteW  = 8;
	localparam int StatW  = 2;
	localparam int CfgIdxW = 2;

	// low nibble mask for rle4 pixel pairs
	localparam logic [ByteW-1:0] NibMask = 8'h0f;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_MODE   = 2'd2
	} cfg_idx_t;

	// parser phases
	typedef enum logic [2:0] {
		PH_COUNT = 3'd0,
		PH_VALUE = 3'd1,
		PH_DX    = 3'd2,
		PH_DY    = 3'd3,
		PH_ABS   = 3'd4,
		PH_PAD   = 3'd5,
		PH_DONE  = 3'd6
	} phase_t;

	// end status codes
	typedef enum logic [StatW-1:0] {
		ST_RUN = 2'd0,
		ST_OK  = 2'd1,
		ST_ERR = 2'd2
	} status_t;

	// escape codes following a zero count
	localparam logic [ByteW-1:0] EscEol   = 8'd0;
	localparam logic [ByteW-1:0] EscEob   = 8'd1;
	localparam logic [ByteW-1:0] EscDelta = 8'd2;

endpackage

[rtl/core/bmp_rle_run_decoder.sv]
// ----------------------------------------------------------------------------
// bmp_rle_run_decoder
// decodes a bmp rle8/rle4 byte stream into clipped pixel runs and end status
// ----------------------------------------------------------------------------
//
// channel   direction  handshake             payload
// in        sink       in_valid / in_ready   data_byte, last_byte
// out       source     out_valid / out_ready pos_x, pos_y, run_length,
//                                            first_value, second_value, end_status
// cfg       sink       cfg_we                cfg_index, cfg_data
//
// one byte per cycle sustained while out_ready holds; each byte is registered in
// the input register, and the parser step loads its result into the result
// register, from which it transfers on out_valid and out_ready
// the parser state update is a single short step, so a byte can enter every
// cycle unless a stalled result blocks it; the result register holds a stalled
// result while the input register keeps one more byte
// arst_n clears the parser, the valid flags and the configuration
// (width 1, height 1, rle8)
// ----------------------------------------------------------------------------
module bmp_rle_run_decoder #(
	parameter int MAX_SIDE = bmprle_pkg::MAX_SIDE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// compressed byte stream
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [bmprle_pkg::ByteW-1:0]    data_byte,
	input  logic                            last_byte,
	// run results
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bmprle_pkg::DimW-1:0]     pos_x,
	output logic [bmprle_pkg::DimW-1:0]     pos_y,
	output logic [bmprle_pkg::ByteW-1:0]    run_length,
	output logic [bmprle_pkg::ByteW-1:0]    first_value,
	output logic [bmprle_pkg::ByteW-1:0]    second_value,
	output logic [bmprle_pkg::StatW-1:0]    end_status,
	// configuration writes
	input  logic                            cfg_we,
	input  logic [bmprle_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bmprle_pkg::DimW-1:0]     cfg_data
);
	import bmprle_pkg::*;

	// side limit at cursor width
	localparam logic [CurW-1:0] MaxSide = CurW'(MAX_SIDE);

	// configuration registers
	logic [DimW-1:0]  image_width_q;
	logic [DimW-1:0]  image_height_q;
	logic             four_bit_mode_q;

	// input register
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             last_s1;

	// parser state
	phase_t           phase_q, phase_d;
	logic [ByteW-1:0] held_q, held_d;
	logic [CurW-1:0]  col_q, col_d;
	logic [CurW-1:0]  row_q, row_d;
	logic [ByteW-1:0] abs_left_q, abs_left_d;
	logic             pad_q, pad_d;

	// result register
	logic             out_valid_s2;
	logic [DimW-1:0]  pos_x_s2, pos_y_s2;
	logic [ByteW-1:0] len_s2, va_s2, vb_s2;
	logic [StatW-1:0] stat_s2;

	// step outputs
	status_t          status;
	logic [ByteW-1:0] n, va, vb, clipped;
	logic [CurW-1:0]  w, room;
	logic [ByteW:0]   byte_inc;
	logic             emit;
	logic             adv;

	function automatic logic [CurW-1:0] sat16(logic [CurW-1:0] a, logic [CurW-1:0] b);
		logic [CurW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CurW] ? {CurW{1'b1}} : s[CurW-1:0];
	endfunction

	// the input register moves on when the result register is free or drains
	assign adv      = valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	// effective width, limited to the side parameter
	assign w        = ({1'b0, image_width_q} > MaxSide) ? MaxSide : {1'b0, image_width_q};
	assign byte_inc = {1'b0, byte_s1} + {{ByteW{1'b0}}, 1'b1};

	// parser step for the byte in the input register
	always_comb begin
		phase_d    = phase_q;
		held_d     = held_q;
		col_d      = col_q;
		row_d      = row_q;
		abs_left_d = abs_left_q;
		pad_d      = pad_q;
		status     = ST_RUN;
		n          = '0;
		va         = '0;
		vb         = '0;
		case (phase_q)
			PH_COUNT: begin
				held_d  = byte_s1;
				phase_d = PH_VALUE;
			end
			PH_VALUE: begin
				if (held_q != '0) begin
					// encoded run
					n       = held_q;
					va      = four_bit_mode_q ? (byte_s1 >> 4) : byte_s1;
					vb      = four_bit_mode_q ? (byte_s1 & NibMask) : byte_s1;
					phase_d = PH_COUNT;
				end else if (byte_s1 == EscEol) begin
					col_d   = '0;
					row_d   = sat16(row_q, CurW'(1));
					phase_d = PH_COUNT;
				end else if (byte_s1 == EscEob) begin
					status  = ST_OK;
					phase_d = PH_DONE;
				end else if (byte_s1 == EscDelta) begin
					phase_d = PH_DX;
					if (last_s1) status = ST_ERR;
				end else begin
					// absolute run, padded to a 16-bit boundary
					abs_left_d = byte_s1;
					pad_d      = four_bit_mode_q ? byte_inc[1] : byte_s1[0];
					phase_d    = PH_ABS;
					if (last_s1) status = ST_ERR;
				end
			end
			PH_DX: begin
				held_d  = byte_s1;
				phase_d = PH_DY;
				if (last_s1) status = ST_ERR;
			end
			PH_DY: begin
				col_d   = sat16(col_q, {{(CurW-ByteW){1'b0}}, held_q});
				row_d   = sat16(row_q, {{(CurW-ByteW){1'b0}}, byte_s1});
				phase_d = PH_COUNT;
			end
			PH_ABS: begin
				if (four_bit_mode_q) begin
					n  = (abs_left_q >= 8'd2) ? 8'd2 : 8'd1;
					va = byte_s1 >> 4;
					vb = byte_s1 & NibMask;
				end else begin
					n  = 8'd1;
					va = byte_s1;
					vb = byte_s1;
				end
				abs_left_d = (abs_left_q > n) ? (abs_left_q - n) : '0;
				if (abs_left_d == '0) begin
					phase_d = pad_q ? PH_PAD : PH_COUNT;
					pad_d   = 1'b0;
				end else if (last_s1) begin
					status = ST_ERR;
				end
			end
			PH_PAD: begin
				phase_d = PH_COUNT;
			end
			default: begin
				// after end of bitmap, skip to the end of the stream
			end
		endcase

		// clip the run against the image and advance the cursor
		room    = w - col_q;
		clipped = '0;
		if (n != '0) begin
			if ((row_q < {1'b0, image_height_q}) && (col_q < w)) begin
				clipped = ({{(CurW-ByteW){1'b0}}, n} < room) ? n : room[ByteW-1:0];
			end
			col_d = sat16(col_q, {{(CurW-ByteW){1'b0}}, n});
		end

		if (last_s1 && (phase_q != PH_DONE) && (status == ST_RUN)) status = ST_OK;

		// final byte rearms the parser for the next stream
		if (last_s1) begin
			phase_d    = PH_COUNT;
			held_d     = '0;
			col_d      = '0;
			row_d      = '0;
			abs_left_d = '0;
			pad_d      = 1'b0;
		end

		emit = (clipped != '0) || (status != ST_RUN);
	end

	// configuration and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= DimW'(1);
			image_height_q  <= DimW'(1);
			four_bit_mode_q <= 1'b0;
			valid_s1        <= 1'b0;
			out_valid_s2    <= 1'b0;
			phase_q         <= PH_COUNT;
			held_q          <= '0;
			col_q           <= '0;
			row_q           <= '0;
			abs_left_q      <= '0;
			pad_q           <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_WIDTH:  image_width_q   <= cfg_data;
					CFG_HEIGHT: image_height_q  <= cfg_data;
					CFG_MODE:   four_bit_mode_q <= cfg_data[0];
					default: begin
						// unused index, write dropped
					end
				endcase
			end
			if (in_ready) valid_s1 <= in_valid;
			if (adv) begin
				out_valid_s2 <= emit;
				phase_q      <= phase_d;
				held_q       <= held_d;
				col_q        <= col_d;
				row_q        <= row_d;
				abs_left_q   <= abs_left_d;
				pad_q        <= pad_d;
			end else if (out_ready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
		if (adv && emit) begin
			// status-only results carry zero fields
			pos_x_s2 <= (clipped != '0) ? col_q[DimW-1:0] : '0;
			pos_y_s2 <= (clipped != '0) ? row_q[DimW-1:0] : '0;
			len_s2   <= clipped;
			va_s2    <= (clipped != '0) ? va : '0;
			vb_s2    <= (clipped != '0) ? vb : '0;
			stat_s2  <= status;
		end
	end

	assign out_valid    = out_valid_s2;
	assign pos_x        = pos_x_s2;
	assign pos_y        = pos_y_s2;
	assign run_length   = len_s2;
	assign first_value  = va_s2;
	assign second_value = vb_s2;
	assign end_status   = stat_s2;

endmodule
